/* src/stks_pkg.sv */
// Shared types and constants for the streaming top-K selector.
package stks_pkg;

	localparam int ID_W    = 31;
	localparam int SCORE_W = 32;

	typedef enum logic {
		ST_IDLE,
		ST_FLUSH
	} ctl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic ins;
		logic pop;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic one_left;
	} dp_status_t;

endpackage

/* src/stks_ctrl.sv */
// Controller state machine of the streaming top-K selector.
module stks_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                is_last,
	input  stks_pkg::dp_status_t status,
	output stks_pkg::dp_cmd_t   cmd,
	output logic                busy
);
	import stks_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.ins = start;
				if (start && is_last) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				busy    = 1'b1;
				cmd.pop = 1'b1;
				if (status.one_left) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* src/stks_dpath.sv */
// Sorted register chain, fill count and result register of the top-K selector.
module stks_dpath #(
	parameter int KEEP_COUNT = 10,
	parameter int SCORE_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  stks_pkg::dp_cmd_t             cmd,
	input  logic [stks_pkg::ID_W-1:0]     item_id,
	input  logic [stks_pkg::SCORE_W-1:0]  score,
	output stks_pkg::dp_status_t          status,
	output logic                          result_valid,
	output logic [stks_pkg::ID_W-1:0]     out_id,
	output logic [stks_pkg::SCORE_W-1:0]  out_score,
	output logic                          out_last
);
	import stks_pkg::*;

	localparam int STORE_W = (SCORE_BITS < SCORE_W) ? SCORE_BITS : SCORE_W;
	localparam int CW      = $clog2(KEEP_COUNT + 1);

	logic [ID_W-1:0]    id_q    [KEEP_COUNT];
	logic [STORE_W-1:0] score_q [KEEP_COUNT];
	logic [ID_W-1:0]    id_d    [KEEP_COUNT];
	logic [STORE_W-1:0] score_d [KEEP_COUNT];
	logic [CW-1:0]      cnt_q;

	logic [STORE_W-1:0] s_in;
	logic               full;
	logic               take;

	// le: entry valid and its score <= incoming score (thermometer, sorted chain).
	// Padded so that lep[i] is le[i-1] with a one below entry 0.
	logic [KEEP_COUNT-1:0] vld;
	logic [KEEP_COUNT:0]   le;
	logic [KEEP_COUNT:0]   eq0;
	logic [KEEP_COUNT:0]   lep;
	logic [KEEP_COUNT:0]   vp;

	logic               res_valid_q;
	logic [ID_W-1:0]    res_id_q;
	logic [STORE_W-1:0] res_score_q;
	logic               res_last_q;

	assign s_in = score[STORE_W-1:0];
	assign full = (cnt_q == CW'(KEEP_COUNT));
	assign take = !full || (s_in > score_q[0]);
	assign status.one_left = (cnt_q == CW'(1));

	always_comb begin
		for (int i = 0; i < KEEP_COUNT; i++) begin
			vld[i] = (CW'(i) < cnt_q);
			le[i]  = vld[i] && (score_q[i] <= s_in);
			eq0[i] = (score_q[i] == score_q[0]);
		end
		le[KEEP_COUNT]  = 1'b0;
		eq0[KEEP_COUNT] = 1'b0;
		lep = {le[KEEP_COUNT-1:0], 1'b1};
		vp  = {vld, 1'b0};
	end

	for (genvar g = 0; g < KEEP_COUNT; g++) begin : g_entry
		logic [ID_W-1:0]    up_id;
		logic [STORE_W-1:0] up_score;
		logic [ID_W-1:0]    dn_id;
		logic [STORE_W-1:0] dn_score;
		logic               ge_j;

		if (g == 0) begin : g_first
			assign up_id    = id_q[g];
			assign up_score = score_q[g];
		end else begin : g_rest
			assign up_id    = id_q[g-1];
			assign up_score = score_q[g-1];
		end
		if (g == KEEP_COUNT - 1) begin : g_last
			assign dn_id    = id_q[g];
			assign dn_score = score_q[g];
		end else begin : g_inner
			assign dn_id    = id_q[g+1];
			assign dn_score = score_q[g+1];
		end

		// At or above the most recent of the entries tied for the lowest score.
		assign ge_j = !eq0[g+1];

		always_comb begin
			id_d[g]    = id_q[g];
			score_d[g] = score_q[g];
			if (cmd.pop) begin
				id_d[g]    = dn_id;
				score_d[g] = dn_score;
			end else if (cmd.ins && take) begin
				if (full) begin
					if (ge_j && le[g+1]) begin
						id_d[g]    = dn_id;
						score_d[g] = dn_score;
					end else if (ge_j && le[g]) begin
						id_d[g]    = item_id;
						score_d[g] = s_in;
					end
				end else begin
					if (vp[g] && !lep[g]) begin
						id_d[g]    = up_id;
						score_d[g] = up_score;
					end else if (!le[g] && lep[g]) begin
						id_d[g]    = item_id;
						score_d[g] = s_in;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < KEEP_COUNT; i++) begin
			id_q[i]    <= id_d[i];
			score_q[i] <= score_d[i];
		end
		if (cmd.pop) begin
			res_id_q    <= id_q[0];
			res_score_q <= score_q[0];
			res_last_q  <= status.one_left;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= cmd.pop;
			if (cmd.pop) begin
				cnt_q <= cnt_q - CW'(1);
			end else if (cmd.ins && !full) begin
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	assign result_valid = res_valid_q;
	assign out_id       = res_id_q;
	assign out_score    = SCORE_W'(res_score_q);
	assign out_last     = res_last_q;

endmodule

/* src/streaming_top_k_selector.sv */
// Top level of the streaming top-K selector: controller plus sorted-chain datapath.
//
//   Channel  Handshake                    Fields
//   -------  ---------------------------  ------------------------------
//   input    start high, busy low         item_id, score, is_last
//   result   result_valid for one cycle   out_id, out_score, out_last
//
// When an item is taken, the sorted register chain compares the incoming score
// with every held entry in parallel and inserts it, evicting the lowest entry
// when the chain is full; a full chain drops an item scoring no higher than its
// lowest entry. Ordinary items go at one per cycle while busy is low. An item
// marked is_last is inserted the same way, then the block holds busy high while
// the chain shifts all held entries (1 to KEEP_COUNT) out lowest score first.
// Results are registered as they leave the chain, so the final result is shown
// in the first cycle with busy low again; a new item may be taken then.
// Reset clears the controller state, the fill count and the result strobe;
// the held entries themselves are not cleared. The receiver cannot stall.
module streaming_top_k_selector #(
	parameter int KEEP_COUNT = 10,
	parameter int SCORE_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [stks_pkg::ID_W-1:0]     item_id,
	input  logic [stks_pkg::SCORE_W-1:0]  score,
	input  logic                          is_last,
	output logic                          result_valid,
	output logic [stks_pkg::ID_W-1:0]     out_id,
	output logic [stks_pkg::SCORE_W-1:0]  out_score,
	output logic                          out_last
);
	import stks_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	// The controller decides when an item is inserted and when the chain drains.
	stks_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.is_last (is_last),
		.status  (status),
		.cmd     (cmd),
		.busy    (busy)
	);

	// The datapath holds the entries sorted by ascending score, ties in arrival order.
	stks_dpath #(
		.KEEP_COUNT (KEEP_COUNT),
		.SCORE_BITS (SCORE_BITS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.item_id      (item_id),
		.score        (score),
		.status       (status),
		.result_valid (result_valid),
		.out_id       (out_id),
		.out_score    (out_score),
		.out_last     (out_last)
	);

endmodule

/* src/stks_chk.sv */
// Port-level checker for the streaming top-K selector and its bind.
module stks_chk (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic is_last,
	input logic result_valid,
	input logic out_last
);

	// A last item that is taken starts the output run.
	a_last_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && is_last |=> busy)
		else $error("last item taken but block not busy");

	// Every result except the final one of a run is shown while busy.
	a_mid_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !out_last |-> busy)
		else $error("non-final result outside of the output run");

	// The run ends exactly with the final result.
	a_end_with_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> result_valid && out_last)
		else $error("output run ended without a final result");

	// Nothing follows the final result directly.
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && out_last |=> !result_valid)
		else $error("result right after the final result");

endmodule

bind streaming_top_k_selector stks_chk u_stks_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.is_last      (is_last),
	.result_valid (result_valid),
	.out_last     (out_last)
);
